FILE: hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the C-like token scanner
// Token kinds, field widths and character class helpers.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int POSITION_BITS = 16;
    localparam int KIND_W        = 5;
    localparam int FIELD_W       = 16;
    localparam int OUT_TDATA_W   = 40;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [FIELD_W-1:0] t_field;

    localparam t_kind K_IDENT    = 5'd0;
    localparam t_kind K_CHAR     = 5'd1;
    localparam t_kind K_STRING   = 5'd2;
    localparam t_kind K_INT      = 5'd3;
    localparam t_kind K_PLUS     = 5'd4;
    localparam t_kind K_MINUS    = 5'd5;
    localparam t_kind K_STAR     = 5'd6;
    localparam t_kind K_SLASH    = 5'd7;
    localparam t_kind K_EQ       = 5'd8;
    localparam t_kind K_ASSIGN   = 5'd9;
    localparam t_kind K_NEQ      = 5'd10;
    localparam t_kind K_LEQ      = 5'd11;
    localparam t_kind K_LT       = 5'd12;
    localparam t_kind K_GEQ      = 5'd13;
    localparam t_kind K_GT       = 5'd14;
    localparam t_kind K_ELLIPSIS = 5'd15;
    localparam t_kind K_DOT      = 5'd16;
    localparam t_kind K_AMP      = 5'd17;
    localparam t_kind K_LPAREN   = 5'd18;
    localparam t_kind K_RPAREN   = 5'd19;
    localparam t_kind K_LBRACK   = 5'd20;
    localparam t_kind K_RBRACK   = 5'd21;
    localparam t_kind K_LBRACE   = 5'd22;
    localparam t_kind K_RBRACE   = 5'd23;
    localparam t_kind K_SEMI     = 5'd24;
    localparam t_kind K_COMMA    = 5'd25;
    localparam t_kind K_EOF      = 5'd26;
    localparam t_kind K_NONE     = 5'd31;

    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;

    typedef enum logic [10:0] {
        M_IDLE   = 11'b000_0000_0001,
        M_IDENT  = 11'b000_0000_0010,
        M_INT    = 11'b000_0000_0100,
        M_CHAR   = 11'b000_0000_1000,
        M_STRING = 11'b000_0001_0000,
        M_EQ     = 11'b000_0010_0000,
        M_BANG   = 11'b000_0100_0000,
        M_LT     = 11'b000_1000_0000,
        M_GT     = 11'b001_0000_0000,
        M_DOT    = 11'b010_0000_0000,
        M_DOTDOT = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        t_field len;
        t_field start;
        t_kind  kind;
    } t_token;

    typedef struct packed {
        logic   last;
        t_token tok;
    } t_entry;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic t_kind single_kind(input logic [7:0] b);
        t_kind k;
        case (b)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h26:   k = K_AMP;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/c_like_token_scanner.sv
// ----------------------------------------------------------------------------
// c_like_token_scanner: byte-serial lexer for a small C-like language
// Takes one source byte per beat and emits identifier, literal, integer,
// operator and EOF tokens through a small result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one source byte per beat in i_s_tdata; i_s_tuser[0] marks
//   end of text (the byte is then ignored). Master side: one token per beat,
//   o_m_tlast set on the final token caused by an input beat.
//   Tokens are registered into the result queue by the input beat that
//   completes them. Throughput: one input beat per cycle while o_s_tready
//   is high; a beat causing two tokens needs two output beats, so the rate
//   is set by the one-token-per-cycle output port of the four-entry queue.
//   The slave side is ready while the queue holds room for two tokens, so
//   the next byte is taken while earlier tokens still wait to be taken.
//   Receiver stall: tokens hold in the queue; once it holds more than two,
//   o_s_tready drops until the receiver drains it. Nothing is lost.
//   Reset: scanner idle, byte offset zero, queue empty. End of text emits
//   any pending token, then EOF, and returns the scanner to its reset state.
// ----------------------------------------------------------------------------
module c_like_token_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,  // in_byte[7:0]
    input  logic [0:0]                     i_s_tuser,  // end_of_input[0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // token_kind[4:0], token_start[20:5], token_length[36:21], zero pad
    output logic [cts_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast   // last_of_run
);

    localparam int PW = cts_pkg::FIFO_PTR_W;

    cts_pkg::t_mode                      r_mode, n_mode;
    cts_pkg::t_field                     r_start, n_start;
    cts_pkg::t_field                     r_run, n_run;
    logic [cts_pkg::POSITION_BITS-1:0]   r_pos, n_pos;

    cts_pkg::t_entry                     r_fifo [cts_pkg::FIFO_DEPTH];
    logic [PW-1:0]                       r_head, r_tail;
    logic [PW:0]                         r_count;

    cts_pkg::t_token tok_a, tok_b;
    logic            tok_a_vld, tok_b_vld;
    logic            taken;
    logic            in_acc, out_acc;
    logic            eoi;
    logic [7:0]      b;
    cts_pkg::t_field pos16;
    cts_pkg::t_field run_inc;
    cts_pkg::t_mode  f_mode;
    cts_pkg::t_kind  f_kind;
    logic [1:0]      n_push;

    assign b       = i_s_tdata;
    assign eoi     = i_s_tuser[0];
    assign pos16   = cts_pkg::t_field'(r_pos);
    assign run_inc = (r_run == '1) ? r_run : r_run + 1'b1;
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_count <= (PW+1)'(cts_pkg::FIFO_DEPTH - 2));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {{(cts_pkg::OUT_TDATA_W - $bits(cts_pkg::t_token)){1'b0}},
                         r_fifo[r_head].tok};
    assign o_m_tlast  = r_fifo[r_head].last;

    // fresh-scan classification of the current byte
    always_comb begin
        f_kind = cts_pkg::single_kind(b);
        if (cts_pkg::is_letter(b)) begin
            f_mode = cts_pkg::M_IDENT;
        end else if (cts_pkg::is_digit(b)) begin
            f_mode = cts_pkg::M_INT;
        end else begin
            case (b)
                cts_pkg::CH_SQUOTE:  f_mode = cts_pkg::M_CHAR;
                cts_pkg::CH_DQUOTE:  f_mode = cts_pkg::M_STRING;
                cts_pkg::CH_EQUAL:   f_mode = cts_pkg::M_EQ;
                cts_pkg::CH_BANG:    f_mode = cts_pkg::M_BANG;
                cts_pkg::CH_LESS:    f_mode = cts_pkg::M_LT;
                cts_pkg::CH_GREATER: f_mode = cts_pkg::M_GT;
                cts_pkg::CH_DOT:     f_mode = cts_pkg::M_DOT;
                default:             f_mode = cts_pkg::M_IDLE;
            endcase
        end
    end

    always_comb begin
        tok_a_vld = 1'b0;
        tok_a     = '{len: r_run, start: r_start, kind: cts_pkg::K_IDENT};
        tok_b_vld = 1'b0;
        tok_b     = '{len: '0, start: pos16, kind: cts_pkg::K_EOF};
        taken     = 1'b0;
        n_mode    = r_mode;
        n_start   = r_start;
        n_run     = r_run;
        n_pos     = r_pos + 1'b1;

        if (eoi) begin
            // flush the pending token, then EOF, then back to reset state
            unique case (r_mode)
                cts_pkg::M_IDENT: begin
                    tok_a_vld = 1'b1;
                end
                cts_pkg::M_INT: begin
                    tok_a_vld  = 1'b1;
                    tok_a.kind = cts_pkg::K_INT;
                end
                cts_pkg::M_CHAR: begin
                    tok_a_vld  = 1'b1;
                    tok_a.kind = cts_pkg::K_CHAR;
                end
                cts_pkg::M_STRING: begin
                    tok_a_vld  = 1'b1;
                    tok_a.kind = cts_pkg::K_STRING;
                end
                cts_pkg::M_EQ: begin
                    tok_a_vld = 1'b1;
                    tok_a     = '{len: 16'd1, start: r_start, kind: cts_pkg::K_ASSIGN};
                end
                cts_pkg::M_LT: begin
                    tok_a_vld = 1'b1;
                    tok_a     = '{len: 16'd1, start: r_start, kind: cts_pkg::K_LT};
                end
                cts_pkg::M_GT: begin
                    tok_a_vld = 1'b1;
                    tok_a     = '{len: 16'd1, start: r_start, kind: cts_pkg::K_GT};
                end
                cts_pkg::M_DOT: begin
                    tok_a_vld = 1'b1;
                    tok_a     = '{len: 16'd1, start: r_start, kind: cts_pkg::K_DOT};
                end
                default: begin
                end
            endcase
            tok_b_vld = 1'b1;
            n_mode    = cts_pkg::M_IDLE;
            n_start   = '0;
            n_run     = '0;
            n_pos     = '0;
        end else begin
            unique case (r_mode)
                cts_pkg::M_IDENT, cts_pkg::M_INT: begin
                    if (cts_pkg::is_digit(b)
                        || (r_mode == cts_pkg::M_IDENT && cts_pkg::is_letter(b))) begin
                        n_run = run_inc;
                        taken = 1'b1;
                    end else begin
                        tok_a_vld  = 1'b1;
                        tok_a.kind = (r_mode == cts_pkg::M_IDENT) ? cts_pkg::K_IDENT
                                                                  : cts_pkg::K_INT;
                    end
                end
                cts_pkg::M_CHAR, cts_pkg::M_STRING: begin
                    // the closing byte counts in the literal
                    n_run = run_inc;
                    taken = 1'b1;
                    if (!cts_pkg::is_letter(b) && !cts_pkg::is_digit(b)) begin
                        tok_a_vld  = 1'b1;
                        tok_a.len  = run_inc;
                        tok_a.kind = (r_mode == cts_pkg::M_CHAR) ? cts_pkg::K_CHAR
                                                                 : cts_pkg::K_STRING;
                        n_mode     = cts_pkg::M_IDLE;
                    end
                end
                cts_pkg::M_EQ, cts_pkg::M_BANG, cts_pkg::M_LT, cts_pkg::M_GT: begin
                    if (b == cts_pkg::CH_EQUAL) begin
                        tok_a_vld = 1'b1;
                        tok_a.len = 16'd2;
                        case (r_mode)
                            cts_pkg::M_EQ:   tok_a.kind = cts_pkg::K_EQ;
                            cts_pkg::M_BANG: tok_a.kind = cts_pkg::K_NEQ;
                            cts_pkg::M_LT:   tok_a.kind = cts_pkg::K_LEQ;
                            default:         tok_a.kind = cts_pkg::K_GEQ;
                        endcase
                        n_mode = cts_pkg::M_IDLE;
                        taken  = 1'b1;
                    end else if (r_mode != cts_pkg::M_BANG) begin
                        // lone bang drops; the others emit their short form
                        tok_a_vld = 1'b1;
                        tok_a.len = 16'd1;
                        case (r_mode)
                            cts_pkg::M_EQ: tok_a.kind = cts_pkg::K_ASSIGN;
                            cts_pkg::M_LT: tok_a.kind = cts_pkg::K_LT;
                            default:       tok_a.kind = cts_pkg::K_GT;
                        endcase
                    end
                end
                cts_pkg::M_DOT: begin
                    if (b == cts_pkg::CH_DOT) begin
                        n_mode = cts_pkg::M_DOTDOT;
                        taken  = 1'b1;
                    end else begin
                        tok_a_vld = 1'b1;
                        tok_a     = '{len: 16'd1, start: r_start, kind: cts_pkg::K_DOT};
                    end
                end
                cts_pkg::M_DOTDOT: begin
                    if (b == cts_pkg::CH_DOT) begin
                        tok_a_vld = 1'b1;
                        tok_a     = '{len: 16'd3, start: r_start, kind: cts_pkg::K_ELLIPSIS};
                        n_mode    = cts_pkg::M_IDLE;
                        taken     = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // rescan the byte as the start of a new token
            if (!taken) begin
                n_start = pos16;
                n_mode  = f_mode;
                n_run   = 16'd1;
                if (f_mode == cts_pkg::M_IDLE && f_kind != cts_pkg::K_NONE) begin
                    tok_b_vld = 1'b1;
                    tok_b     = '{len: 16'd1, start: pos16, kind: f_kind};
                end
            end
            if (n_mode == cts_pkg::M_IDLE) begin
                n_run = '0;
            end
        end
    end

    assign n_push = {1'b0, tok_a_vld} + {1'b0, tok_b_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cts_pkg::M_IDLE;
            r_start <= '0;
            r_run   <= '0;
            r_pos   <= '0;
        end else if (in_acc) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_run   <= n_run;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (out_acc) begin
                r_head <= r_head + 1'b1;
            end
            if (in_acc) begin
                r_tail <= r_tail + PW'(n_push);
            end
            r_count <= r_count + (in_acc ? (PW+1)'(n_push) : '0) - (PW+1)'(out_acc);
        end
    end

    // queue payload, written in token order with last on the final one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (tok_a_vld && tok_b_vld) begin
                r_fifo[r_tail]        <= '{last: 1'b0, tok: tok_a};
                r_fifo[r_tail + 1'b1] <= '{last: 1'b1, tok: tok_b};
            end else if (tok_a_vld) begin
                r_fifo[r_tail] <= '{last: 1'b1, tok: tok_a};
            end else if (tok_b_vld) begin
                r_fifo[r_tail] <= '{last: 1'b1, tok: tok_b};
            end
        end
    end

endmodule

FILE: hdl/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker: port-level checks for the C-like token scanner
// Watches both stream channels and the token fields over time.
// ----------------------------------------------------------------------------
module cts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [0:0]                      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [cts_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                            o_m_tlast
);

    // hold a stalled token beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("token beat changed while stalled");

    // end of text always queues an EOF token
    a_eoi_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser[0] |=> o_m_tvalid)
        else $error("no token after end of text");

    // EOF closes its run and has zero length
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4:0] == cts_pkg::K_EOF |->
            o_m_tlast && o_m_tdata[36:21] == '0)
        else $error("malformed EOF token");

    // back-pressure only comes from queued tokens
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty queue");

endmodule

bind c_like_token_scanner cts_checker u_cts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

FILE: verif/tb_c_like_token_scanner.sv
// ----------------------------------------------------------------------------
// tb_c_like_token_scanner: self-checking bench for the C-like token scanner
// Feeds source text beats with random gaps, predicts every token from a
// behavioral lexer and checks each output beat in order against it.
// ----------------------------------------------------------------------------
module tb_c_like_token_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        int         gap;
    } t_text_beat;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata  = '0;
    logic [0:0]             i_s_tuser  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    c_like_token_scanner uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),  // in_byte[7:0]
        .i_s_tuser  (i_s_tuser),  // end_of_input[0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),  // kind[4:0], start[20:5], length[36:21], pad
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioral lexer
    // ------------------------------------------------------------------
    t_mode                    scan_mode = M_IDLE;
    t_field                   tok_start = '0;
    t_field                   tok_len   = '0;
    logic [POSITION_BITS-1:0] scan_pos  = '0;

    t_entry beat_toks[$];
    t_entry tokens_due[$];
    int     errors = 0;

    function automatic logic letter_byte(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
    endfunction

    function automatic logic digit_byte(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic t_kind punct_kind(logic [7:0] b);
        t_kind k;
        case (b)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "&":     k = K_AMP;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            ",":     k = K_COMMA;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic t_field len_inc(t_field v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void add_tok(t_kind k, t_field s, t_field n);
        t_entry e;
        e.last      = 1'b0;
        e.tok.kind  = k;
        e.tok.start = s;
        e.tok.len   = n;
        beat_toks.push_back(e);
    endfunction

    task automatic lex_beat(input logic [7:0] b, input logic eot);
        logic                     took;
        logic [POSITION_BITS-1:0] here;
        t_kind                    pk;
        took = 1'b0;
        here = scan_pos;
        beat_toks.delete();
        if (eot) begin
            // flush the pending token, then EOF, then back to reset state
            case (scan_mode)
                M_IDENT:  add_tok(K_IDENT, tok_start, tok_len);
                M_INT:    add_tok(K_INT, tok_start, tok_len);
                M_CHAR:   add_tok(K_CHAR, tok_start, tok_len);
                M_STRING: add_tok(K_STRING, tok_start, tok_len);
                M_EQ:     add_tok(K_ASSIGN, tok_start, 16'd1);
                M_LT:     add_tok(K_LT, tok_start, 16'd1);
                M_GT:     add_tok(K_GT, tok_start, 16'd1);
                M_DOT:    add_tok(K_DOT, tok_start, 16'd1);
                default: ;
            endcase
            add_tok(K_EOF, here[FIELD_W-1:0], '0);
            scan_mode = M_IDLE;
            tok_start = '0;
            tok_len   = '0;
            scan_pos  = '0;
        end else begin
            case (scan_mode)
                M_IDENT, M_INT: begin
                    if (digit_byte(b) || (scan_mode == M_IDENT && letter_byte(b))) begin
                        tok_len = len_inc(tok_len);
                        took    = 1'b1;
                    end else begin
                        add_tok(scan_mode == M_IDENT ? K_IDENT : K_INT, tok_start, tok_len);
                    end
                end
                M_CHAR, M_STRING: begin
                    // any byte other than a letter or digit closes and is counted
                    tok_len = len_inc(tok_len);
                    if (!letter_byte(b) && !digit_byte(b)) begin
                        add_tok(scan_mode == M_CHAR ? K_CHAR : K_STRING, tok_start, tok_len);
                        scan_mode = M_IDLE;
                    end
                    took = 1'b1;
                end
                M_EQ, M_BANG, M_LT, M_GT: begin
                    if (b == CH_EQUAL) begin
                        case (scan_mode)
                            M_EQ:    pk = K_EQ;
                            M_BANG:  pk = K_NEQ;
                            M_LT:    pk = K_LEQ;
                            default: pk = K_GEQ;
                        endcase
                        add_tok(pk, tok_start, 16'd2);
                        scan_mode = M_IDLE;
                        took      = 1'b1;
                    end else if (scan_mode != M_BANG) begin
                        case (scan_mode)
                            M_EQ:    pk = K_ASSIGN;
                            M_LT:    pk = K_LT;
                            default: pk = K_GT;
                        endcase
                        add_tok(pk, tok_start, 16'd1);
                    end
                end
                M_DOT: begin
                    if (b == CH_DOT) begin
                        scan_mode = M_DOTDOT;
                        took      = 1'b1;
                    end else begin
                        add_tok(K_DOT, tok_start, 16'd1);
                    end
                end
                M_DOTDOT: begin
                    if (b == CH_DOT) begin
                        add_tok(K_ELLIPSIS, tok_start, 16'd3);
                        scan_mode = M_IDLE;
                        took      = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!took) begin
                // scan the byte as the first of a new token
                tok_start = here[FIELD_W-1:0];
                tok_len   = 16'd1;
                if (letter_byte(b)) begin
                    scan_mode = M_IDENT;
                end else if (digit_byte(b)) begin
                    scan_mode = M_INT;
                end else begin
                    case (b)
                        CH_SQUOTE:  scan_mode = M_CHAR;
                        CH_DQUOTE:  scan_mode = M_STRING;
                        CH_EQUAL:   scan_mode = M_EQ;
                        CH_BANG:    scan_mode = M_BANG;
                        CH_LESS:    scan_mode = M_LT;
                        CH_GREATER: scan_mode = M_GT;
                        CH_DOT:     scan_mode = M_DOT;
                        default: begin
                            scan_mode = M_IDLE;
                            pk = punct_kind(b);
                            if (pk != K_NONE) add_tok(pk, here[FIELD_W-1:0], 16'd1);
                        end
                    endcase
                end
            end
            if (scan_mode == M_IDLE) tok_len = '0;
            scan_pos = here + 1'b1;
        end
        if (beat_toks.size() > 0) beat_toks[beat_toks.size()-1].last = 1'b1;
        foreach (beat_toks[i]) tokens_due.push_back(beat_toks[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    t_text_beat text_beats[$];
    bit         gen_gaps  = 1'b1;
    int         gen_count = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_byte(input logic [7:0] c, input logic eot);
        t_text_beat tb;
        tb.ch  = c;
        tb.eot = eot;
        tb.gap = gen_gaps ? idle_len() : 0;
        text_beats.push_back(tb);
        gen_count++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] word_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + (r - 26));
        if (r == 52) return CH_UNDER;
        return 8'("0" + (r - 53));
    endfunction

    function automatic string op_text(int idx);
        case (idx)
            0:  return "=";
            1:  return "==";
            2:  return "!=";
            3:  return "!";
            4:  return "<";
            5:  return "<=";
            6:  return ">";
            7:  return ">=";
            8:  return ".";
            9:  return "..";
            10: return "...";
            11: return "+";
            12: return "-";
            13: return "*";
            14: return "/";
            15: return "&";
            16: return "(";
            17: return ")";
            18: return "[";
            19: return "]";
            20: return "{";
            21: return "}";
            22: return ";";
            default: return ",";
        endcase
    endfunction

    task automatic put_random_tokens(input int n);
        int stop_at;
        int r;
        int len;
        stop_at = gen_count + n;
        while (gen_count < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                len = $urandom_range(1, 8);
                put_byte(word_char(1'b1), 1'b0);
                for (int i = 1; i < len; i++) put_byte(word_char(1'b0), 1'b0);
            end else if (r < 30) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    put_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
            end else if (r < 38) begin
                put_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++) put_byte(word_char(1'b0), 1'b0);
                // closing byte: a quote half the time, else a space or anything
                case ($urandom_range(0, 3))
                    0:       put_byte(CH_SQUOTE, 1'b0);
                    1:       put_byte(CH_DQUOTE, 1'b0);
                    2:       put_byte(CH_SPACE, 1'b0);
                    default: put_byte(8'($urandom_range(0, 255)), 1'b0);
                endcase
            end else if (r < 60) begin
                put_text(op_text($urandom_range(0, 23)));
            end else if (r < 84) begin
                case ($urandom_range(0, 2))
                    0:       put_byte(CH_SPACE, 1'b0);
                    1:       put_byte(8'h0A, 1'b0);
                    default: put_byte(8'h09, 1'b0);
                endcase
            end else if (r < 95) begin
                put_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Source driver
    // ------------------------------------------------------------------
    t_text_beat cur_beat;
    t_text_beat next_beat;
    bit         have_next = 1'b0;
    int         src_wait  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) lex_beat(cur_beat.ch, cur_beat.eot);
            if (!i_s_tvalid || o_s_tready) begin
                if (!have_next && text_beats.size() > 0) begin
                    next_beat = text_beats.pop_front();
                    have_next = 1'b1;
                    src_wait  = next_beat.gap;
                end
                if (have_next && src_wait == 0) begin
                    cur_beat   = next_beat;
                    have_next  = 1'b0;
                    i_s_tdata  <= next_beat.ch;
                    i_s_tuser  <= next_beat.eot;
                    i_s_tvalid <= 1'b1;
                end else begin
                    if (src_wait > 0) src_wait--;
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink: random gaps, idle-free windows and two long hold-offs
    // ------------------------------------------------------------------
    int snk_cycle  = 0;
    int snk_beats  = 0;
    int snk_gap    = 0;
    int snk_hold   = 0;
    bit hold1_done = 1'b0;
    bit hold2_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            snk_cycle++;
            if (o_m_tvalid && i_m_tready) snk_beats++;
            if (snk_hold > 0) begin
                snk_hold--;
                i_m_tready <= 1'b0;
            end else if ((!hold1_done && snk_beats >= 100) ||
                         (!hold2_done && snk_beats >= 900)) begin
                // long hold: the queue fills and the input must stall
                if (!hold1_done) hold1_done = 1'b1;
                else hold2_done = 1'b1;
                snk_hold = $urandom_range(300, 500);
                i_m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (snk_cycle[9] && $urandom_range(0, 3) == 0) snk_gap = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Token checker
    // ------------------------------------------------------------------
    t_entry want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token: expected none, %s%0d start=%0d len=%0d last=%0b",
                         $time, "actual kind=", o_m_tdata[4:0], o_m_tdata[20:5],
                         o_m_tdata[36:21], o_m_tlast);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                if (o_m_tdata[4:0] != want.tok.kind || o_m_tdata[20:5] != want.tok.start ||
                    o_m_tdata[36:21] != want.tok.len || o_m_tlast != want.last ||
                    o_m_tdata[OUT_TDATA_W-1:37] != '0) begin
                    $display("%0t: token mismatch: expected kind=%0d start=%0d len=%0d last=%0b,",
                             $time, want.tok.kind, want.tok.start, want.tok.len, want.last);
                    $display("    actual kind=%0d start=%0d len=%0d last=%0b pad=%0h",
                             o_m_tdata[4:0], o_m_tdata[20:5], o_m_tdata[36:21], o_m_tlast,
                             o_m_tdata[OUT_TDATA_W-1:37]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no beat on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d tokens outstanding",
                         $time, quiet_cycles, tokens_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // directed: comparison operators, lone bang, ellipsis, double dot, wide bytes
        put_text("_Zz9 ==!=!<<=>>=...,..&");
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b1);
        // char closed by a quote, identifier flushed by EOF, repeated EOF
        put_text("'a\"b");
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b1);

        put_random_tokens(400);
        gen_gaps = 1'b0;
        put_random_tokens(250);
        // long identifier sent back to back
        put_byte(8'h00, 1'b1);
        put_byte(word_char(1'b1), 1'b0);
        for (int i = 1; i < 24; i++) put_byte(word_char(1'b0), 1'b0);
        gen_gaps = 1'b1;
        put_random_tokens(200);
        put_random_tokens(400);
        put_byte(8'h00, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (text_beats.size() != 0 || have_next || i_s_tvalid) @(negedge i_clk);
        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
